FILE: hw/rtl/assert_macros.svh
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, switched off while reset is held.
`define RHIC_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("rhic: assertion failed");

// Next-cycle implication, switched off while reset is held.
`define RHIC_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("rhic: assertion failed");

`endif

FILE: hw/rtl/rhic_pkg.sv
`default_nettype none

package rhic_pkg;

    localparam int MAX_DIM    = 1024;
    localparam int DIM_W      = 11;
    localparam int IDX_W      = 20;
    localparam int CELL_W     = 10;
    localparam int ACC_W      = 21;
    localparam int VEC_W      = 12;
    localparam int CRD_W      = 13;
    localparam int CFG_IDX_W  = 1;

    localparam logic [DIM_W-1:0] GRID_RESET = DIM_W'(32);

    localparam logic [CFG_IDX_W-1:0] REG_GRID_WIDTH  = 1'b0;
    localparam logic [CFG_IDX_W-1:0] REG_GRID_HEIGHT = 1'b1;

    typedef struct packed {
        logic load;
        logic check;
        logic split;
        logic step;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic oor;
        logic leaf;
    } t_sts;

endpackage

`default_nettype wire

FILE: hw/rtl/rhic_ifs.sv
`default_nettype none

interface rhic_in_if import rhic_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              mode;
    logic [IDX_W-1:0]  in_index;
    logic [CELL_W-1:0] in_cell_x;
    logic [CELL_W-1:0] in_cell_y;

    modport source (output valid, mode, in_index, in_cell_x, in_cell_y, input ready);
    modport sink   (input valid, mode, in_index, in_cell_x, in_cell_y, output ready);
endinterface

interface rhic_out_if import rhic_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [IDX_W-1:0]  out_index;
    logic [CELL_W-1:0] out_cell_x;
    logic [CELL_W-1:0] out_cell_y;
    logic              out_of_range;

    modport source (output valid, out_index, out_cell_x, out_cell_y, out_of_range,
                    input ready);
    modport sink   (input valid, out_index, out_cell_x, out_cell_y, out_of_range,
                    output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/rhic_ctrl.sv
`default_nettype none

module rhic_ctrl import rhic_pkg::*; (
    input  wire  i_clk,
    input  wire  i_rst_n,
    input  wire  i_in_valid,
    output logic o_in_ready,
    output logic o_out_valid,
    input  wire  i_out_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    localparam int ST_W = 3;
    localparam logic [ST_W-1:0] ST_IDLE  = 3'd0;
    localparam logic [ST_W-1:0] ST_CHECK = 3'd1;
    localparam logic [ST_W-1:0] ST_SPLIT = 3'd2;
    localparam logic [ST_W-1:0] ST_STEP  = 3'd3;
    localparam logic [ST_W-1:0] ST_EMIT  = 3'd4;

    logic [ST_W-1:0] r_state, n_state;
    logic            r_out_valid, n_out_valid;
    logic            accept;
    logic            out_free;

    assign o_in_ready  = (r_state == ST_IDLE) && i_rst_n;
    assign accept      = i_in_valid && o_in_ready;
    assign out_free    = !r_out_valid || i_out_ready;
    assign o_out_valid = r_out_valid;

    always_comb begin
        o_cmd       = '0;
        n_state     = r_state;
        o_cmd.load  = accept;
        unique case (r_state)
            ST_IDLE: begin
                if (accept) begin
                    n_state = ST_CHECK;
                end
            end
            ST_CHECK: begin
                o_cmd.check = 1'b1;
                n_state     = i_sts.oor ? ST_EMIT : ST_SPLIT;
            end
            ST_SPLIT: begin
                o_cmd.split = 1'b1;
                n_state     = ST_STEP;
            end
            ST_STEP: begin
                o_cmd.step = 1'b1;
                n_state    = i_sts.leaf ? ST_EMIT : ST_SPLIT;
            end
            ST_EMIT: begin
                if (out_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_comb begin
        priority if (o_cmd.emit) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

`default_nettype wire

FILE: hw/rtl/rhic_dpath.sv
`default_nettype none

module rhic_dpath import rhic_pkg::*; (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_cfg_we,
    input  wire  [CFG_IDX_W-1:0]   i_cfg_idx,
    input  wire  [DIM_W-1:0]       i_cfg_data,
    input  wire                    i_mode,
    input  wire  [IDX_W-1:0]       i_index,
    input  wire  [CELL_W-1:0]      i_cell_x,
    input  wire  [CELL_W-1:0]      i_cell_y,
    input  t_cmd                   i_cmd,
    output t_sts                   o_sts,
    output logic [IDX_W-1:0]       o_index,
    output logic [CELL_W-1:0]      o_cell_x,
    output logic [CELL_W-1:0]      o_cell_y,
    output logic                   o_oor
);

    function automatic logic [DIM_W-1:0] clamp_dim(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] r;
        r = v;
        if (v == '0) begin
            r = DIM_W'(1);
        end else if (v > DIM_W'(MAX_DIM)) begin
            r = DIM_W'(MAX_DIM);
        end
        return r;
    endfunction

    function automatic logic [DIM_W-1:0] mag(input logic signed [CRD_W-1:0] v);
        logic signed [CRD_W-1:0] t;
        t = (v < 0) ? -v : v;
        return t[DIM_W-1:0];
    endfunction

    function automatic logic signed [CRD_W-1:0] sgn(input logic signed [CRD_W-1:0] v);
        logic signed [CRD_W-1:0] r;
        r = '0;
        if (v > 0) begin
            r = CRD_W'(1);
        end else if (v < 0) begin
            r = -CRD_W'(1);
        end
        return r;
    endfunction

    // Half-open containment of point q in the rectangle at (x0, y0) spanned by va and vb.
    function automatic logic holds(
        input logic signed [CRD_W-1:0] qx, input logic signed [CRD_W-1:0] qy,
        input logic signed [CRD_W-1:0] x0, input logic signed [CRD_W-1:0] y0,
        input logic signed [CRD_W-1:0] vax, input logic signed [CRD_W-1:0] vay,
        input logic signed [CRD_W-1:0] vbx, input logic signed [CRD_W-1:0] vby
    );
        logic signed [CRD_W-1:0] dx;
        logic signed [CRD_W-1:0] dy;
        logic                    okx;
        logic                    oky;
        dx  = vax + vbx;
        dy  = vay + vby;
        okx = (dx < 0) ? (qx <= x0 && qx > x0 + dx) : (qx >= x0 && qx < x0 + dx);
        oky = (dy < 0) ? (qy <= y0 && qy > y0 + dy) : (qy >= y0 && qy < y0 + dy);
        return okx && oky;
    endfunction

    logic [DIM_W-1:0]        r_grid_w, r_grid_h;
    logic                    r_mode;
    logic [IDX_W-1:0]        r_idx;
    logic [CELL_W-1:0]       r_px, r_py;
    logic [DIM_W-1:0]        r_cx, r_cy;
    logic signed [VEC_W-1:0] r_ax, r_ay, r_bx, r_by;
    logic [ACC_W-1:0]        r_acc;
    logic                    r_oor;
    logic                    r_major, r_leaf;
    logic signed [VEC_W-1:0] r_a2x, r_a2y, r_b2x, r_b2y;
    logic [ACC_W-1:0]        r_n1, r_n2;
    logic [CELL_W-1:0]       r_ox, r_oy;
    logic [IDX_W-1:0]        r_out_index;
    logic [CELL_W-1:0]       r_out_x, r_out_y;
    logic                    r_out_oor;

    // Current rectangle, widened for coordinate arithmetic.
    logic signed [CRD_W-1:0] ax, ay, bx, by, x, y, px, py;
    logic signed [CRD_W-1:0] dax, day, dbx, dby;
    logic signed [CRD_W-1:0] ax2, ay2, bx2, by2;
    logic [DIM_W-1:0]        w, h, w2, h2, wa2, hb2, m1a, m1b;
    logic [DIM_W+1:0]        w_x2, h_x3;
    logic                    major, adj_a, adj_b;
    logic [2*DIM_W-1:0]      n1_full, n2_full, total;
    logic                    n_oor;

    // Registered split, widened.
    logic signed [CRD_W-1:0] a2x, a2y, b2x, b2y;
    logic [ACC_W-1:0]        t1, t2, d;
    logic                    in1, in2;
    logic signed [CRD_W-1:0] n_cx, n_cy, n_ax, n_ay, n_bx, n_by;
    logic [ACC_W-1:0]        n_acc;

    // Leaf walk.
    logic signed [CRD_W-1:0] sx, sy, lx, ly, tx, ty, dis, ox, oy;
    logic [ACC_W-1:0]        di, leaf_acc;

    assign ax = CRD_W'(r_ax);
    assign ay = CRD_W'(r_ay);
    assign bx = CRD_W'(r_bx);
    assign by = CRD_W'(r_by);
    assign x  = signed'({{(CRD_W-DIM_W){1'b0}}, r_cx});
    assign y  = signed'({{(CRD_W-DIM_W){1'b0}}, r_cy});
    assign px = signed'({{(CRD_W-CELL_W){1'b0}}, r_px});
    assign py = signed'({{(CRD_W-CELL_W){1'b0}}, r_py});

    assign total = r_grid_w * r_grid_h;
    assign n_oor = r_mode ? ({1'b0, r_px} >= r_grid_w || {1'b0, r_py} >= r_grid_h)
                          : ({2'b0, r_idx} >= total);

    always_comb begin
        dax   = sgn(ax);
        day   = sgn(ay);
        dbx   = sgn(bx);
        dby   = sgn(by);
        w     = mag(ax + ay);
        h     = mag(bx + by);
        ax2   = ax >>> 1;
        ay2   = ay >>> 1;
        bx2   = bx >>> 1;
        by2   = by >>> 1;
        w2    = mag(ax2 + ay2);
        h2    = mag(bx2 + by2);
        w_x2  = {1'b0, w, 1'b0};
        h_x3  = {2'b0, h} + {1'b0, h, 1'b0};
        major = w_x2 > h_x3;
        // An odd half of a long side is grown by one so the split stays even.
        adj_a = w2[0] && (w > DIM_W'(2));
        adj_b = h2[0] && (h > DIM_W'(2));
        wa2   = w2 + DIM_W'(adj_a);
        hb2   = h2 + DIM_W'(adj_b);
        m1a   = major ? wa2 : hb2;
        m1b   = major ? h : w2;
    end

    assign n1_full = m1a * m1b;
    assign n2_full = w * (h - hb2);

    always_comb begin
        a2x = CRD_W'(r_a2x);
        a2y = CRD_W'(r_a2y);
        b2x = CRD_W'(r_b2x);
        b2y = CRD_W'(r_b2y);
        d   = {1'b0, r_idx};
        t1  = r_acc + r_n1;
        t2  = t1 + r_n2;
        if (r_mode) begin
            in1 = r_major ? holds(px, py, x, y, a2x, a2y, bx, by)
                          : holds(px, py, x, y, b2x, b2y, a2x, a2y);
            in2 = holds(px, py, x + b2x, y + b2y, ax, ay, bx - b2x, by - b2y);
        end else begin
            in1 = d < t1;
            in2 = d < t2;
        end

        n_cx  = x;
        n_cy  = y;
        n_ax  = ax;
        n_ay  = ay;
        n_bx  = bx;
        n_by  = by;
        n_acc = r_acc;
        if (r_major) begin
            if (in1) begin
                n_ax = a2x;
                n_ay = a2y;
            end else begin
                n_acc = t1;
                n_cx  = x + a2x;
                n_cy  = y + a2y;
                n_ax  = ax - a2x;
                n_ay  = ay - a2y;
            end
        end else begin
            priority if (in1) begin
                n_ax = b2x;
                n_ay = b2y;
                n_bx = a2x;
                n_by = a2y;
            end else if (in2) begin
                n_acc = t1;
                n_cx  = x + b2x;
                n_cy  = y + b2y;
                n_bx  = bx - b2x;
                n_by  = by - b2y;
            end else begin
                // Third child runs back along the far side, towards the origin edge.
                n_acc = t2;
                n_cx  = x + (ax - dax) + (b2x - dbx);
                n_cy  = y + (ay - day) + (b2y - dby);
                n_ax  = -b2x;
                n_ay  = -b2y;
                n_bx  = -(ax - a2x);
                n_by  = -(ay - a2y);
            end
        end
    end

    always_comb begin
        sx       = (h == DIM_W'(1)) ? dax : dbx;
        sy       = (h == DIM_W'(1)) ? day : dby;
        lx       = px - x;
        ly       = py - y;
        tx       = (sx > 0) ? lx : ((sx < 0) ? -lx : '0);
        ty       = (sy > 0) ? ly : ((sy < 0) ? -ly : '0);
        leaf_acc = r_acc + ACC_W'(tx + ty);
        di       = d - r_acc;
        dis      = signed'(di[CRD_W-1:0]);
        ox       = x + ((sx > 0) ? dis : ((sx < 0) ? -dis : '0));
        oy       = y + ((sy > 0) ? dis : ((sy < 0) ? -dis : '0));
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_grid_w <= GRID_RESET;
            r_grid_h <= GRID_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                REG_GRID_WIDTH:  r_grid_w <= clamp_dim(i_cfg_data);
                REG_GRID_HEIGHT: r_grid_h <= clamp_dim(i_cfg_data);
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode <= i_mode;
            r_idx  <= i_index;
            r_px   <= i_cell_x;
            r_py   <= i_cell_y;
        end
        if (i_cmd.check) begin
            r_oor <= n_oor;
            r_cx  <= '0;
            r_cy  <= '0;
            r_ax  <= signed'({{(VEC_W-DIM_W){1'b0}}, r_grid_w});
            r_ay  <= '0;
            r_bx  <= '0;
            r_by  <= signed'({{(VEC_W-DIM_W){1'b0}}, r_grid_h});
            r_acc <= '0;
        end
        if (i_cmd.split) begin
            r_major <= major;
            r_leaf  <= (w == DIM_W'(1)) || (h == DIM_W'(1));
            r_a2x   <= VEC_W'(ax2 + ((major && adj_a) ? dax : '0));
            r_a2y   <= VEC_W'(ay2 + ((major && adj_a) ? day : '0));
            r_b2x   <= VEC_W'(bx2 + ((!major && adj_b) ? dbx : '0));
            r_b2y   <= VEC_W'(by2 + ((!major && adj_b) ? dby : '0));
            r_n1    <= n1_full[ACC_W-1:0];
            r_n2    <= n2_full[ACC_W-1:0];
        end
        if (i_cmd.step) begin
            if (r_leaf) begin
                if (r_mode) begin
                    r_acc <= leaf_acc;
                end else begin
                    r_ox <= ox[CELL_W-1:0];
                    r_oy <= oy[CELL_W-1:0];
                end
            end else begin
                r_cx  <= n_cx[DIM_W-1:0];
                r_cy  <= n_cy[DIM_W-1:0];
                r_ax  <= VEC_W'(n_ax);
                r_ay  <= VEC_W'(n_ay);
                r_bx  <= VEC_W'(n_bx);
                r_by  <= VEC_W'(n_by);
                r_acc <= n_acc;
            end
        end
        if (i_cmd.emit) begin
            r_out_oor   <= r_oor;
            r_out_index <= (r_oor || !r_mode) ? '0 : r_acc[IDX_W-1:0];
            r_out_x     <= (r_oor || r_mode) ? '0 : r_ox;
            r_out_y     <= (r_oor || r_mode) ? '0 : r_oy;
        end
    end

    assign o_sts.oor  = n_oor;
    assign o_sts.leaf = r_leaf;
    assign o_index    = r_out_index;
    assign o_cell_x   = r_out_x;
    assign o_cell_y   = r_out_y;
    assign o_oor      = r_out_oor;

endmodule

`default_nettype wire

FILE: hw/rtl/rect_hilbert_index_converter.sv
`default_nettype none

// Converts between a position along a generalised Hilbert curve and a cell (x, y) of a
// grid_width by grid_height rectangle (each clamped to 1..1024): mode 0 maps an index to a
// cell, mode 1 maps a cell to an index, and an index or cell outside the grid returns
// out_of_range with all other fields zero. One request is handled at a time. The descent
// shares one split unit that works through each subdivision level as the products, then
// the child choice. An out-of-range request skips the descent. The next request is taken
// in the cycle after a result is loaded. The result sits in an output register, so the
// next request is taken while an earlier result still waits, but a finished result
// stalls until the earlier one has been taken.
module rect_hilbert_index_converter import rhic_pkg::*; (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_cfg_we,
    input  wire  [CFG_IDX_W-1:0] i_cfg_idx,
    input  wire  [DIM_W-1:0]     i_cfg_data,
    rhic_in_if.sink              i_in,
    rhic_out_if.source           o_out
);

    t_cmd cmd;
    t_sts sts;
    logic in_ready;
    logic out_valid;

    rhic_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (in_ready),
        .o_out_valid (out_valid),
        .i_out_ready (o_out.ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    rhic_dpath u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_idx  (i_cfg_idx),
        .i_cfg_data (i_cfg_data),
        .i_mode     (i_in.mode),
        .i_index    (i_in.in_index),
        .i_cell_x   (i_in.in_cell_x),
        .i_cell_y   (i_in.in_cell_y),
        .i_cmd      (cmd),
        .o_sts      (sts),
        .o_index    (o_out.out_index),
        .o_cell_x   (o_out.out_cell_x),
        .o_cell_y   (o_out.out_cell_y),
        .o_oor      (o_out.out_of_range)
    );

    assign i_in.ready  = in_ready;
    assign o_out.valid = out_valid;

endmodule

`default_nettype wire

FILE: hw/rtl/rhic_checker.sv
`default_nettype none

`include "assert_macros.svh"

module rhic_checker import rhic_pkg::*; (
    input wire              i_clk,
    input wire              i_rst_n,
    input wire              i_in_valid,
    input wire              i_in_ready,
    input wire              i_out_valid,
    input wire              i_out_ready,
    input wire [IDX_W-1:0]  i_out_index,
    input wire [CELL_W-1:0] i_out_cell_x,
    input wire [CELL_W-1:0] i_out_cell_y,
    input wire              i_out_of_range
);

    logic cells_zero;
    logic fields_zero;

    assign cells_zero  = (i_out_cell_x == '0) && (i_out_cell_y == '0);
    assign fields_zero = (i_out_index == '0) && cells_zero;

    // A result that has not been taken stays on offer.
    `RHIC_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, i_out_valid && !i_out_ready, i_out_valid)

    // A flagged result carries nothing else.
    `RHIC_ASSERT_IMP(a_oor_zero, i_clk, i_rst_n, i_out_valid && i_out_of_range, fields_zero)

    // A cell-to-index result never carries a cell as well.
    `RHIC_ASSERT_IMP(a_one_kind, i_clk, i_rst_n, i_out_valid && (i_out_index != '0), cells_zero)

    // Requests are worked on one at a time.
    `RHIC_ASSERT_NEXT(a_one_request, i_clk, i_rst_n, i_in_valid && i_in_ready, !i_in_ready)

endmodule

bind rect_hilbert_index_converter rhic_checker u_rhic_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in.valid),
    .i_in_ready     (i_in.ready),
    .i_out_valid    (o_out.valid),
    .i_out_ready    (o_out.ready),
    .i_out_index    (o_out.out_index),
    .i_out_cell_x   (o_out.out_cell_x),
    .i_out_cell_y   (o_out.out_cell_y),
    .i_out_of_range (o_out.out_of_range)
);

`default_nettype wire
